// ===== hw/rtl/blg_pkg.sv =====
// ----------------------------------------------------------------------------
// blg_pkg
// shared types, constants and the bit-sliced life rule for the generation engine
// ----------------------------------------------------------------------------
package blg_pkg;

    localparam int WORD_W          = 64;
    localparam int ROW_W           = 8;
    localparam int WIDX_W          = 2;
    localparam int GRID_SIDE_DEF   = 256;
    localparam int ROW_WORDS_DEF   = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic in_range;
    } req_hdr_t;

    typedef struct packed {
        logic init_busy;
    } blg_status_t;

    // one row of the neighborhood: center word plus wrap bits from the side words
    function automatic logic [WORD_W-1:0] west_vec(input logic [WORD_W-1:0] mid,
                                                   input logic west_bit);
        west_vec = {mid[WORD_W-2:0], west_bit};
    endfunction

    function automatic logic [WORD_W-1:0] east_vec(input logic [WORD_W-1:0] mid,
                                                   input logic east_bit);
        east_vec = {east_bit, mid[WORD_W-1:1]};
    endfunction

    function automatic logic [WORD_W-1:0] life_word(
        input logic [WORD_W-1:0] t_mid, input logic t_w, input logic t_e,
        input logic [WORD_W-1:0] c_mid, input logic c_w, input logic c_e,
        input logic [WORD_W-1:0] b_mid, input logic b_w, input logic b_e);
        logic [WORD_W-1:0] v [8];
        logic [WORD_W-1:0] c0;
        logic [WORD_W-1:0] c1;
        logic [WORD_W-1:0] c2;
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        v[0] = west_vec(t_mid, t_w);
        v[1] = east_vec(t_mid, t_e);
        v[2] = t_mid;
        v[3] = west_vec(c_mid, c_w);
        v[4] = east_vec(c_mid, c_e);
        v[5] = west_vec(b_mid, b_w);
        v[6] = east_vec(b_mid, b_e);
        v[7] = b_mid;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        for (int i = 0; i < 8; i++) begin
            k0 = c0 & v[i];
            c0 = c0 ^ v[i];
            k1 = c1 & k0;
            c1 = c1 ^ k0;
            c2 = c2 ^ k1;
        end
        life_word = (~c2 & c1 & c0) | (~c2 & c1 & ~c0 & c_mid);
    endfunction

endpackage

// ===== hw/rtl/blg_ram.sv =====
// ----------------------------------------------------------------------------
// blg_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module blg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/blg_front.sv =====
// ----------------------------------------------------------------------------
// blg_front
// accepts command requests, checks the address and queues them for the back end
// ----------------------------------------------------------------------------
module blg_front #(
    parameter int GRID_SIDE = blg_pkg::GRID_SIDE_DEF,
    parameter int ROW_WORDS = blg_pkg::ROW_WORDS_DEF,
    parameter int AW        = $clog2(GRID_SIDE * ROW_WORDS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [blg_pkg::ROW_W-1:0]  s_row,
    input  logic [blg_pkg::WIDX_W-1:0] s_word_index,
    input  logic [blg_pkg::WORD_W-1:0] s_write_data,
    input  blg_pkg::blg_status_t       stat,
    output logic                       q_valid,
    input  logic                       q_pop,
    output blg_pkg::req_hdr_t          q_hdr,
    output logic [AW-1:0]              q_addr,
    output logic [blg_pkg::WORD_W-1:0] q_data
);

    localparam int PW = $clog2(blg_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(blg_pkg::QUEUE_DEPTH + 1);

    blg_pkg::req_hdr_t          hdr_q  [blg_pkg::QUEUE_DEPTH];
    logic [AW-1:0]              addr_q [blg_pkg::QUEUE_DEPTH];
    logic [blg_pkg::WORD_W-1:0] data_q [blg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]              wr_ptr_reg;
    logic [PW-1:0]              rd_ptr_reg;
    logic [NW-1:0]              count_reg;
    logic [NW-1:0]              count_next;
    logic                       push;
    blg_pkg::req_hdr_t          new_hdr;
    logic [AW-1:0]              new_addr;

    assign s_ready = (count_reg != NW'(blg_pkg::QUEUE_DEPTH)) && !stat.init_busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_hdr   = hdr_q[rd_ptr_reg];
    assign q_addr  = addr_q[rd_ptr_reg];
    assign q_data  = data_q[rd_ptr_reg];

    always_comb begin
        new_hdr.cmd      = blg_pkg::cmd_t'(s_cmd);
        new_hdr.in_range = (32'(s_row) < 32'(GRID_SIDE)) &&
                           (32'(s_word_index) < 32'(ROW_WORDS));
        new_addr         = AW'(32'(s_row) * 32'(ROW_WORDS) + 32'(s_word_index));
        count_next       = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + NW'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
        if (push) begin
            hdr_q[wr_ptr_reg]  <= new_hdr;
            addr_q[wr_ptr_reg] <= new_addr;
            data_q[wr_ptr_reg] <= s_write_data;
        end
    end

endmodule

// ===== hw/rtl/blg_back.sv =====
// ----------------------------------------------------------------------------
// blg_back
// executes queued requests: word access, bank clear and the generation sweep
// ----------------------------------------------------------------------------
module blg_back #(
    parameter int GRID_SIDE = blg_pkg::GRID_SIDE_DEF,
    parameter int ROW_WORDS = blg_pkg::ROW_WORDS_DEF,
    parameter int AW        = $clog2(GRID_SIDE * ROW_WORDS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  blg_pkg::req_hdr_t          q_hdr,
    input  logic [AW-1:0]              q_addr,
    input  logic [blg_pkg::WORD_W-1:0] q_data,
    output blg_pkg::blg_status_t       stat,
    output logic                       ram_we_a,
    output logic                       ram_we_b,
    output logic [AW-1:0]              ram_waddr,
    output logic [blg_pkg::WORD_W-1:0] ram_wdata,
    output logic [AW-1:0]              ram_raddr,
    input  logic [blg_pkg::WORD_W-1:0] rdata_a,
    input  logic [blg_pkg::WORD_W-1:0] rdata_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [blg_pkg::WORD_W-1:0] m_read_data,
    output logic [1:0]                 m_done_cmd
);

    localparam int BANK_WORDS = GRID_SIDE * ROW_WORDS;
    localparam int KW  = $clog2(GRID_SIDE + 2);
    localparam int CW  = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int YW  = $clog2(GRID_SIDE);
    localparam int WW  = blg_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_STEP,
        S_DRAIN1,
        S_DRAIN2
    } state_t;

    state_t          state_reg;
    logic            cur_reg;
    logic            init_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [CW-1:0]   col_reg;
    logic [KW-1:0]   k_reg;
    logic [1:0]      ph_reg;
    logic            dv_reg;
    logic [1:0]      dph_reg;
    logic            demit_reg;
    logic [AW-1:0]   daddr_reg;
    logic            tmp_w_reg;
    logic [WW-1:0]   tmp_mid_reg;
    logic [WW-1:0]   t_mid_reg;
    logic            t_w_reg;
    logic            t_e_reg;
    logic [WW-1:0]   c_mid_reg;
    logic            c_w_reg;
    logic            c_e_reg;
    logic [WW-1:0]   b_mid_reg;
    logic            b_w_reg;
    logic            b_e_reg;
    logic            calc_valid_reg;
    logic [AW-1:0]   calc_addr_reg;
    logic            rd_inrange_reg;
    logic            m_valid_reg;
    logic [WW-1:0]   m_read_data_reg;
    logic [1:0]      m_done_reg;

    logic            out_free;
    logic [WW-1:0]   rdata;
    logic [YW-1:0]   ry;
    logic [CW-1:0]   wsel;
    logic [AW-1:0]   step_raddr;
    logic [AW-1:0]   step_oaddr;
    logic            we;
    logic            wbank;

    assign out_free    = !m_valid_reg || m_ready;
    assign q_pop       = (state_reg == S_IDLE) && q_valid && out_free;
    assign rdata       = cur_reg ? rdata_b : rdata_a;
    assign stat.init_busy = init_reg;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_done_cmd  = m_done_reg;

    // row and word of the next neighborhood read, wrapping at the edges
    always_comb begin
        if (k_reg == '0) begin
            ry = YW'(GRID_SIDE - 1);
        end else if (32'(k_reg) == 32'(GRID_SIDE + 1)) begin
            ry = '0;
        end else begin
            ry = YW'(k_reg - KW'(1));
        end
        case (ph_reg)
            2'd0:    wsel = (col_reg == '0) ? CW'(ROW_WORDS - 1) : col_reg - CW'(1);
            2'd2:    wsel = (32'(col_reg) == 32'(ROW_WORDS - 1)) ? '0 : col_reg + CW'(1);
            default: wsel = col_reg;
        endcase
        step_raddr = AW'(32'(ry) * 32'(ROW_WORDS) + 32'(wsel));
        step_oaddr = AW'((32'(k_reg) - 32'd2) * 32'(ROW_WORDS) + 32'(col_reg));
    end

    always_comb begin
        we        = 1'b0;
        wbank     = cur_reg;
        ram_waddr = q_addr;
        ram_wdata = q_data;
        ram_raddr = (state_reg == S_IDLE) ? q_addr : step_raddr;
        if (state_reg == S_CLR) begin
            we        = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (calc_valid_reg) begin
            we        = 1'b1;
            wbank     = !cur_reg;
            ram_waddr = calc_addr_reg;
            ram_wdata = blg_pkg::life_word(t_mid_reg, t_w_reg, t_e_reg,
                                           c_mid_reg, c_w_reg, c_e_reg,
                                           b_mid_reg, b_w_reg, b_e_reg);
        end else if (q_pop && q_hdr.cmd == blg_pkg::CMD_WRITE && q_hdr.in_range) begin
            we = 1'b1;
        end
        ram_we_a = we && !wbank;
        ram_we_b = we && wbank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            cur_reg        <= 1'b0;
            init_reg       <= 1'b1;
            clr_cnt_reg    <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            ph_reg         <= '0;
            dv_reg         <= 1'b0;
            calc_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            dv_reg         <= 1'b0;
            calc_valid_reg <= dv_reg && (dph_reg == 2'd2) && demit_reg;
            unique case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (32'(clr_cnt_reg) == 32'(BANK_WORDS - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                        if (!init_reg) begin
                            m_valid_reg     <= 1'b1;
                            m_read_data_reg <= '0;
                            m_done_reg      <= blg_pkg::CMD_CLEAR;
                        end
                        init_reg <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (q_pop) begin
                        unique case (q_hdr.cmd)
                            blg_pkg::CMD_WRITE: begin
                                m_valid_reg     <= 1'b1;
                                m_read_data_reg <= '0;
                                m_done_reg      <= blg_pkg::CMD_WRITE;
                            end
                            blg_pkg::CMD_READ: begin
                                rd_inrange_reg <= q_hdr.in_range;
                                state_reg      <= S_RD;
                            end
                            blg_pkg::CMD_STEP: begin
                                col_reg   <= '0;
                                k_reg     <= '0;
                                ph_reg    <= '0;
                                state_reg <= S_STEP;
                            end
                            blg_pkg::CMD_CLEAR: begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    m_valid_reg     <= 1'b1;
                    m_read_data_reg <= rd_inrange_reg ? rdata : '0;
                    m_done_reg      <= blg_pkg::CMD_READ;
                    state_reg       <= S_IDLE;
                end
                S_STEP: begin
                    dv_reg    <= 1'b1;
                    dph_reg   <= ph_reg;
                    demit_reg <= (k_reg >= KW'(2));
                    daddr_reg <= step_oaddr;
                    if (ph_reg == 2'd2) begin
                        ph_reg <= '0;
                        if (32'(k_reg) == 32'(GRID_SIDE + 1)) begin
                            k_reg <= '0;
                            if (32'(col_reg) == 32'(ROW_WORDS - 1)) begin
                                state_reg <= S_DRAIN1;
                            end else begin
                                col_reg <= col_reg + CW'(1);
                            end
                        end else begin
                            k_reg <= k_reg + KW'(1);
                        end
                    end else begin
                        ph_reg <= ph_reg + 2'd1;
                    end
                end
                S_DRAIN1: begin
                    state_reg <= S_DRAIN2;
                end
                S_DRAIN2: begin
                    cur_reg         <= !cur_reg;
                    m_valid_reg     <= 1'b1;
                    m_read_data_reg <= '0;
                    m_done_reg      <= blg_pkg::CMD_STEP;
                    state_reg       <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
        // neighborhood window, shifts down one row per three reads
        if (dv_reg) begin
            calc_addr_reg <= daddr_reg;
            case (dph_reg)
                2'd0: tmp_w_reg <= rdata[WW-1];
                2'd1: tmp_mid_reg <= rdata;
                default: begin
                    t_mid_reg <= c_mid_reg;
                    t_w_reg   <= c_w_reg;
                    t_e_reg   <= c_e_reg;
                    c_mid_reg <= b_mid_reg;
                    c_w_reg   <= b_w_reg;
                    c_e_reg   <= b_e_reg;
                    b_mid_reg <= tmp_mid_reg;
                    b_w_reg   <= tmp_w_reg;
                    b_e_reg   <= rdata[0];
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/bitsliced_life_generation.sv =====
// step: new generation written to the other bank, three bank reads per word
// one request in execution at a time; a 2-entry queue takes requests meanwhile
// after reset a clearing pass zeroes bank a, s_ready stays low
// ----------------------------------------------------------------------------
// bitsliced_life_generation
// toroidal bit-sliced life engine with word access, clear and generation step
// ----------------------------------------------------------------------------
module bitsliced_life_generation #(
    parameter int GRID_SIDE = blg_pkg::GRID_SIDE_DEF,
    parameter int ROW_WORDS = blg_pkg::ROW_WORDS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_cmd,
    input  logic [blg_pkg::ROW_W-1:0]  s_row,
    input  logic [blg_pkg::WIDX_W-1:0] s_word_index,
    input  logic [blg_pkg::WORD_W-1:0] s_write_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [blg_pkg::WORD_W-1:0] m_read_data,
    output logic [1:0]                 m_done_cmd
);

    localparam int BANK_WORDS = GRID_SIDE * ROW_WORDS;
    localparam int AW = $clog2(BANK_WORDS);

    blg_pkg::blg_status_t       stat;
    blg_pkg::req_hdr_t          q_hdr;
    logic                       q_valid;
    logic                       q_pop;
    logic [AW-1:0]              q_addr;
    logic [blg_pkg::WORD_W-1:0] q_data;
    logic                       ram_we_a;
    logic                       ram_we_b;
    logic [AW-1:0]              ram_waddr;
    logic [blg_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [blg_pkg::WORD_W-1:0] rdata_a;
    logic [blg_pkg::WORD_W-1:0] rdata_b;

    blg_front #(
        .GRID_SIDE (GRID_SIDE),
        .ROW_WORDS (ROW_WORDS),
        .AW        (AW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_row        (s_row),
        .s_word_index (s_word_index),
        .s_write_data (s_write_data),
        .stat         (stat),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_hdr        (q_hdr),
        .q_addr       (q_addr),
        .q_data       (q_data)
    );

    blg_back #(
        .GRID_SIDE (GRID_SIDE),
        .ROW_WORDS (ROW_WORDS),
        .AW        (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_hdr       (q_hdr),
        .q_addr      (q_addr),
        .q_data      (q_data),
        .stat        (stat),
        .ram_we_a    (ram_we_a),
        .ram_we_b    (ram_we_b),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_done_cmd  (m_done_cmd)
    );

    blg_ram #(
        .WIDTH (blg_pkg::WORD_W),
        .DEPTH (BANK_WORDS)
    ) u_bank_a (
        .aclk  (aclk),
        .we    (ram_we_a),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_a)
    );

    blg_ram #(
        .WIDTH (blg_pkg::WORD_W),
        .DEPTH (BANK_WORDS)
    ) u_bank_b (
        .aclk  (aclk),
        .we    (ram_we_b),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata_b)
    );

endmodule
